>>> src/assert_macros.svh
// Assertion helper macros for the path hash core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AST_ALWAYS(label, clk, rst, prop, msg)
`define AST_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> src/pnh_pkg.sv
// Shared types and constants for the path normalize / FNV-1a 64 hash core.
`timescale 1ns / 1ps
package pnh_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Work unit handed from the classifier to the hash engine.
   typedef struct packed {
      logic       first_vld;
      logic [7:0] first_byte;
      logic       second_vld;
      logic [7:0] second_byte;
      logic       end_item;
   } pnh_entry_type;

   typedef enum logic [1:0] {
      BK_FIRST,
      BK_SECOND,
      BK_EMIT
   } bk_state_type;

endpackage

>>> src/pnh_front.sv
// Front end: normalizes path bytes and turns each item into hash work.
`timescale 1ns / 1ps
module pnh_front
   import pnh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          take,        // item accepted this cycle
   input  logic [7:0]    path_byte,
   input  logic          end_marker,
   output logic          push,
   output pnh_entry_type entry
);

   logic at_start_ff, at_start_in;
   logic held_dot_ff, held_dot_in;
   logic pend_sep_ff, pend_sep_in;

   logic       is_sep;
   logic [7:0] byte_low;

   assign is_sep   = (path_byte == CHR_BSLASH) || (path_byte == CHR_SLASH);
   assign byte_low = (path_byte inside {[CHR_UPPER_A:CHR_UPPER_Z]}) ?
                     path_byte + CASE_OFFSET : path_byte;

   always_comb begin
      at_start_in = at_start_ff;
      held_dot_in = held_dot_ff;
      pend_sep_in = pend_sep_ff;
      entry       = '0;
      if (end_marker) begin
         // lone leading dot is hashed before the result
         entry.first_vld  = at_start_ff && held_dot_ff;
         entry.first_byte = CHR_DOT;
         entry.end_item   = 1'b1;
         at_start_in      = 1'b1;
         held_dot_in      = 1'b0;
         pend_sep_in      = 1'b0;
      end else if (at_start_ff) begin
         if (held_dot_ff) begin
            held_dot_in = 1'b0;
            if (!is_sep) begin
               entry.first_vld   = 1'b1;
               entry.first_byte  = CHR_DOT;
               entry.second_vld  = 1'b1;
               entry.second_byte = byte_low;
               at_start_in       = 1'b0;
            end
         end else if (is_sep) begin
            // leading separator dropped
         end else if (path_byte == CHR_DOT) begin
            held_dot_in = 1'b1;
         end else begin
            entry.first_vld  = 1'b1;
            entry.first_byte = byte_low;
            at_start_in      = 1'b0;
         end
      end else if (is_sep) begin
         pend_sep_in = 1'b1;
      end else if (pend_sep_ff) begin
         entry.first_vld   = 1'b1;
         entry.first_byte  = CHR_SLASH;
         entry.second_vld  = 1'b1;
         entry.second_byte = byte_low;
         pend_sep_in       = 1'b0;
      end else begin
         entry.first_vld  = 1'b1;
         entry.first_byte = byte_low;
      end
   end

   assign push = take && (entry.first_vld || entry.end_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         held_dot_ff <= 1'b0;
         pend_sep_ff <= 1'b0;
      end else if (take) begin
         at_start_ff <= at_start_in;
         held_dot_ff <= held_dot_in;
         pend_sep_ff <= pend_sep_in;
      end
   end

endmodule

>>> src/pnh_queue.sv
// Small FIFO of hash work between the front end and the hash engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pnh_queue
   import pnh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pnh_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          head_vld,
   output pnh_entry_type head
);

   pnh_entry_type entries_ff [QDEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign head_vld = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `AST_NEVER(a_q_overflow, clock, reset, push && full, "push into full work queue")
   `AST_NEVER(a_q_underflow, clock, reset, pop && !head_vld, "pop from empty work queue")
   `AST_ALWAYS(a_q_count, clock, reset, count_ff <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

>>> src/pnh_back.sv
// Hash engine: one FNV-1a round per cycle unless rsp_ stalls, then emits the identifier.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pnh_back
   import pnh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_vld,
   input  pnh_entry_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata
);

   bk_state_type state_ff, state_in;

   logic [63:0] hash_ff, hash_in;
   logic        out_vld_ff, out_vld_in;
   logic [63:0] out_data_ff;

   logic        out_free;
   logic        do_fold;
   logic        emit;
   logic [7:0]  fold_byte;
   logic [63:0] mix;
   logic [63:0] folded;

   assign out_free = !out_vld_ff || rsp_tready;

   // prime = 2^40 + 0x1B3, so the multiply is a fixed shift-add
   assign mix    = hash_ff ^ {56'b0, fold_byte};
   assign folded = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) +
                   (mix << 4) + (mix << 1) + mix;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_FIRST: begin
            if (head_vld && head.first_vld) begin
               if (head.second_vld) begin
                  state_in = BK_SECOND;
               end else if (head.end_item) begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_SECOND: state_in = BK_FIRST;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_FIRST;
            end
         end
         default: state_in = BK_FIRST;
      endcase
   end

   always_comb begin
      do_fold   = 1'b0;
      emit      = 1'b0;
      pop       = 1'b0;
      fold_byte = head.first_byte;
      case (state_ff)
         BK_FIRST: begin
            if (head_vld) begin
               if (head.first_vld) begin
                  do_fold = 1'b1;
                  pop     = !head.second_vld && !head.end_item;
               end else begin
                  emit = out_free;
                  pop  = out_free;
               end
            end
         end
         BK_SECOND: begin
            do_fold   = 1'b1;
            fold_byte = head.second_byte;
            pop       = 1'b1;
         end
         BK_EMIT: begin
            emit = out_free;
            pop  = out_free;
         end
         default: begin
            do_fold = 1'b0;
         end
      endcase
   end

   always_comb begin
      hash_in    = hash_ff;
      out_vld_in = out_vld_ff;
      if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
      if (do_fold) begin
         hash_in = folded;
      end else if (emit) begin
         hash_in    = FNV_BASIS;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_FIRST;
         hash_ff    <= FNV_BASIS;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hash_ff    <= hash_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_data_ff <= (hash_ff == '0) ? 64'd1 : hash_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   `AST_ALWAYS(a_bk_second, clock, reset, (state_ff == BK_SECOND) |-> (head_vld && head.second_vld), "second round without a second byte")
   `AST_ALWAYS(a_bk_emit, clock, reset, (state_ff == BK_EMIT) |-> (head_vld && head.end_item), "emit state without an end item")
   `AST_ALWAYS(a_bk_rehash, clock, reset, emit |=> (hash_ff == FNV_BASIS), "hash not reseeded after emit")

endmodule

>>> src/path_normalize_fnv1a64_hash_core.sv
// Top level: path normalizer with FNV-1a 64 hash, split into front end, queue and hash engine.
`timescale 1ns / 1ps
// A byte item is folded in 1 or 2 hash rounds once it reaches the head of the work queue.
// An end item's identifier goes through the engine output register to rsp_ after earlier work.
// The front takes one item per cycle while the queue is not full; the engine does one round
// per cycle unless rsp_ stalls, and emits an end item at once or after folding a held dot.
// The 2-entry work queue lets the front keep taking items while the engine or rsp_ stalls.
// Reset (synchronous, active high) reseeds the hash and clears queue and output.
module path_normalize_fnv1a64_hash_core
   import pnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] path_byte
   input  logic        req_tlast,    // end_marker
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata     // [63:0] identifier
);

   logic          q_full;
   logic          take;
   logic          push;
   pnh_entry_type push_entry;
   logic          pop;
   logic          head_vld;
   pnh_entry_type head;

   // front never waits on the engine directly, only on queue space
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   pnh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .path_byte  (req_tdata),
      .end_marker (req_tlast),
      .push       (push),
      .entry      (push_entry)
   );

   pnh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_vld   (head_vld),
      .head       (head)
   );

   // engine owns the rsp_ output register
   pnh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_vld   (head_vld),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
